>>> rtl/vms_pkg.sv
// Shared types and constants for the vend motor sequencer.
`timescale 1ns / 1ps
package vms_pkg;

  localparam int REG_W   = 10;
  localparam int IDX_W   = 4;
  localparam int ROW_W   = 6;
  localparam int COL_W   = 9;
  localparam int PHASE_W = 2;
  localparam int CFG_IDX_W = 2;

  localparam logic [7:0] LAYER_BASE   = 8'h41;
  localparam logic [7:0] CHANNEL_BASE = 8'h31;

  localparam logic [PHASE_W-1:0] PH_IDLE   = 2'd0;
  localparam logic [PHASE_W-1:0] PH_FIRST  = 2'd1;
  localparam logic [PHASE_W-1:0] PH_LEAVE  = 2'd2;
  localparam logic [PHASE_W-1:0] PH_ARRIVE = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BADCH   = 2'd1;
  localparam logic [1:0] ST_LEAVETO = 2'd2;
  localparam logic [1:0] ST_ARRTO   = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_LEAVE_LIMIT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ARRIVE_LIMIT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_DRIVE    = 2'd2;

  localparam logic [REG_W-1:0] LEAVE_LIMIT_RST  = 10'd200;
  localparam logic [REG_W-1:0] ARRIVE_LIMIT_RST = 10'd400;
  localparam logic [REG_W-1:0] MIN_DRIVE_RST    = 10'd150;

  typedef struct packed {
    logic [REG_W-1:0] leave_limit;
    logic [REG_W-1:0] arrive_limit;
    logic [REG_W-1:0] min_drive_ticks;
  } cfg_t;

  typedef struct packed {
    logic [REG_W-1:0] drive_ticks;
    logic [1:0]       status;
    logic             done_res;
    logic             busy_res;
    logic             motor_power;
    logic [COL_W-1:0] col_lines;
    logic [ROW_W-1:0] row_lines;
  } res_t;

endpackage

>>> rtl/vms_cfg.sv
// Configuration register file for the vend motor sequencer.
`timescale 1ns / 1ps
module vms_cfg
  import vms_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [REG_W-1:0]     cfg_data,
  output cfg_t                 cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.leave_limit     <= LEAVE_LIMIT_RST;
      cfg.arrive_limit    <= ARRIVE_LIMIT_RST;
      cfg.min_drive_ticks <= MIN_DRIVE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LEAVE_LIMIT:  cfg.leave_limit     <= cfg_data;
        REG_ARRIVE_LIMIT: cfg.arrive_limit    <= cfg_data;
        REG_MIN_DRIVE:    cfg.min_drive_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

>>> rtl/vms_core.sv
// Sequencer state and per-beat next-state and result logic.
`timescale 1ns / 1ps
module vms_core
  import vms_pkg::*;
#(
  parameter int ROW_COUNT = 6,
  parameter int COL_COUNT = 9
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       fire,
  input  logic       command,
  input  logic [7:0] layer_char,
  input  logic [7:0] channel_char,
  input  logic       home_sensor,
  input  cfg_t       cfg,
  output res_t       res
);

  logic [PHASE_W-1:0] phase, phase_next;
  logic [IDX_W-1:0]   row_index, row_index_next;
  logic [IDX_W-1:0]   col_index, col_index_next;
  logic [REG_W-1:0]   countdown, countdown_next;
  logic [REG_W-1:0]   arrive_elapsed, arrive_elapsed_next;
  logic               retry_used, retry_used_next;
  logic               direct_path, direct_path_next;

  logic [IDX_W-1:0] r, c;
  logic             leaving, hit, active;
  logic             done;
  logic [1:0]       status;
  logic [REG_W-1:0] ticks;
  logic [15:0]      row_onehot, col_onehot;

  assign r = IDX_W'(layer_char - LAYER_BASE);
  assign c = IDX_W'(channel_char - CHANNEL_BASE);

  always_comb begin
    phase_next          = phase;
    row_index_next      = row_index;
    col_index_next      = col_index;
    countdown_next      = countdown;
    arrive_elapsed_next = arrive_elapsed;
    retry_used_next     = retry_used;
    direct_path_next    = direct_path;
    done    = 1'b0;
    status  = ST_OK;
    ticks   = '0;
    hit     = 1'b0;
    leaving = (phase == PH_LEAVE);
    if (fire) begin
      if (command) begin
        if (phase == PH_IDLE) begin
          if (r >= IDX_W'(ROW_COUNT) || c >= IDX_W'(COL_COUNT)) begin
            done   = 1'b1;
            status = ST_BADCH;
          end else begin
            row_index_next      = r;
            col_index_next      = c;
            retry_used_next     = 1'b0;
            direct_path_next    = 1'b0;
            arrive_elapsed_next = '0;
            countdown_next      = '0;
            phase_next          = PH_FIRST;
          end
        end
      end else begin
        unique case (phase) inside
          PH_FIRST: begin
            if (home_sensor) begin
              direct_path_next = 1'b0;
              phase_next       = PH_LEAVE;
              countdown_next   = cfg.leave_limit;
            end else begin
              direct_path_next    = 1'b1;
              phase_next          = PH_ARRIVE;
              countdown_next      = cfg.arrive_limit;
              arrive_elapsed_next = '0;
            end
          end
          PH_LEAVE, PH_ARRIVE: begin
            if (countdown != '0) begin
              hit = leaving ? !home_sensor : home_sensor;
              if (!hit) begin
                countdown_next = countdown - REG_W'(1);
                if (!leaving) begin
                  arrive_elapsed_next = arrive_elapsed + REG_W'(1);
                end
              end
            end
            if (hit) begin
              if (leaving) begin
                phase_next          = PH_ARRIVE;
                countdown_next      = cfg.arrive_limit;
                arrive_elapsed_next = '0;
              end else if (direct_path && !retry_used &&
                           arrive_elapsed_next <= cfg.min_drive_ticks) begin
                retry_used_next  = 1'b1;
                direct_path_next = 1'b0;
                phase_next       = PH_LEAVE;
                countdown_next   = cfg.leave_limit;
              end else begin
                phase_next = PH_IDLE;
                done       = 1'b1;
                status     = ST_OK;
                ticks      = arrive_elapsed_next;
              end
            end else if (countdown_next == '0) begin
              phase_next = PH_IDLE;
              done       = 1'b1;
              status     = leaving ? ST_LEAVETO : ST_ARRTO;
              ticks      = leaving ? '0 : arrive_elapsed_next;
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    active     = (phase_next != PH_IDLE);
    row_onehot = 16'd1 << row_index_next;
    col_onehot = 16'd1 << col_index_next;
    res.row_lines   = active ? ~row_onehot[ROW_W-1:0] : '1;
    res.col_lines   = active ? col_onehot[COL_W-1:0] : '0;
    res.motor_power = active;
    res.busy_res    = active;
    res.done_res    = done;
    res.status      = status;
    res.drive_ticks = ticks;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      row_index      <= '0;
      col_index      <= '0;
      countdown      <= '0;
      arrive_elapsed <= '0;
      retry_used     <= 1'b0;
      direct_path    <= 1'b0;
    end else begin
      phase          <= phase_next;
      row_index      <= row_index_next;
      col_index      <= col_index_next;
      countdown      <= countdown_next;
      arrive_elapsed <= arrive_elapsed_next;
      retry_used     <= retry_used_next;
      direct_path    <= direct_path_next;
    end
  end

endmodule

>>> rtl/vend_motor_sequencer_top.sv
// Top level of the vend motor sequencer: input stage, core and result register.
//
//  channel  dir  beat contents
//  s_*      in   tuser: command; tdata: layer_char, channel_char, home_sensor
//  m_*      out  tdata: row_lines .. drive_ticks, one beat per input beat
//  cfg_*    in   write enable, register index, 10-bit data
//
// One beat per cycle sustained while m_tready stays high; an accepted input beat
// passes through the input register, then core logic into the result register.
// rst is synchronous and clears the sequencer to idle with default limits.
// A stalled output holds the result; the input register keeps accepting while
// the result register can drain in the same cycle.
`timescale 1ns / 1ps
module vend_motor_sequencer_top
  import vms_pkg::*;
#(
  parameter int ROW_COUNT = 6,
  parameter int COL_COUNT = 9
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [23:0]          s_tdata,  // layer_char, channel_char, home_sensor
  input  logic                 s_tuser,  // command
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // row_lines, col_lines, motor_power, busy_res, done_res, status, drive_ticks
  output logic [31:0]          m_tdata,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [REG_W-1:0]     cfg_data
);

  logic       in_valid;
  logic       in_cmd;
  logic [7:0] in_layer;
  logic [7:0] in_chan;
  logic       in_home;
  logic       adv, fire;
  cfg_t       cfg;
  res_t       res;

  assign adv      = !m_tvalid || m_tready;
  assign fire     = in_valid && adv;
  assign s_tready = !in_valid || adv;

  vms_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  vms_core #(
    .ROW_COUNT (ROW_COUNT),
    .COL_COUNT (COL_COUNT)
  ) u_core (
    .clk          (clk),
    .rst          (rst),
    .fire         (fire),
    .command      (in_cmd),
    .layer_char   (in_layer),
    .channel_char (in_chan),
    .home_sensor  (in_home),
    .cfg          (cfg),
    .res          (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (fire) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_cmd   <= s_tuser;
      in_layer <= s_tdata[7:0];
      in_chan  <= s_tdata[15:8];
      in_home  <= s_tdata[16];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      m_tdata <= {2'b00, res};
    end
  end

endmodule

>>> rtl/vms_checker.sv
// Port-level checks for the vend motor sequencer, bound to the top level.
`timescale 1ns / 1ps
module vms_checker
  import vms_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result beat changed while stalled");

  a_power_busy: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[15] == m_tdata[16])
    else $error("motor power and busy disagree");

  a_status_done: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[17] |-> m_tdata[19:18] == ST_OK && m_tdata[29:20] == '0)
    else $error("status or ticks reported without done");

  a_idle_lines: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[16] |-> m_tdata[5:0] == '1 && m_tdata[14:6] == '0)
    else $error("lines driven while idle");

endmodule

bind vend_motor_sequencer_top vms_checker u_vms_checker (.*);
